>>> rtl/hbdt_pkg.sv
// Package for the motor bridge direction and dead-time controller: types and constants.
package hbdt_pkg;

    localparam int DutyW     = 12;
    localparam int TickW     = 8;
    localparam int DebW      = 16;
    localparam int AddrW     = 5;
    localparam int DataW     = 32;

    localparam logic [TickW-1:0] DebounceTicksRst = 8'd20;
    localparam logic [DutyW-1:0] FastDutyRst      = 12'd2880;
    localparam logic [DutyW-1:0] SlowDutyRst      = 12'd1260;
    localparam logic [DutyW-1:0] StartDutyRst     = 12'd1800;
    localparam logic [TickW-1:0] DeadTicksRst     = 8'd2;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_FAST     = 3'd1,
        REG_SLOW     = 3'd2,
        REG_START    = 3'd3,
        REG_DEAD     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_STOP  = 2'd1,
        PH_RAISE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [DutyW-1:0] left_compare;
        logic [DutyW-1:0] right_compare;
        logic             left_low_on;
        logic             right_low_on;
        logic             pwm_running;
        logic             led_on;
        dir_t             direction;
        logic             switching;
    } result_t;

endpackage

>>> rtl/hbridge_direction_deadtime_ctrl.sv
// Top level: motor bridge direction control with dead time, debounced speed buttons.
//
// One item per 1 ms tick on the item channel (item_valid/item_stall) carries the
// direction switch level and the fast/slow button edges seen during that tick.
// Each accepted item yields exactly one result item on the result channel
// (result_valid/result_stall): both high-side compares, both low-side drives,
// PWM run, LED, direction and the switching flag, as they stand after the tick.
// One item per cycle is sustained while item_stall is low, set by the single pass
// of next-state logic between the state registers and the result register. A
// two-entry output stage (result register plus skid register) keeps the item side
// open while one result waits; with both entries full item_stall rises and stays
// high until the receiver takes one, and result_valid comes from a register.
// Registers on the APB-style port (byte address 4*i): debounce_ticks, fast_duty,
// slow_duty, start_duty, dead_ticks. Reset loads their defaults, sets direction
// idle, clears compares, low sides, PWM and LED, and loads the duty with the
// default start duty.
module hbridge_direction_deadtime_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hbdt_pkg::AddrW-1:0]  paddr,
    input  logic [hbdt_pkg::DataW-1:0]  pwdata,
    output logic [hbdt_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        forward_switch,
    input  logic                        fast_edge,
    input  logic                        slow_edge,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [hbdt_pkg::DutyW-1:0]  left_compare,
    output logic [hbdt_pkg::DutyW-1:0]  right_compare,
    output logic                        left_low_on,
    output logic                        right_low_on,
    output logic                        pwm_running,
    output logic                        led_on,
    output logic [1:0]                  direction,
    output logic                        switching
);
    import hbdt_pkg::*;

    logic [TickW-1:0] debounce_ticks_reg;
    logic [DutyW-1:0] fast_duty_reg;
    logic [DutyW-1:0] slow_duty_reg;
    logic [DutyW-1:0] start_duty_reg;
    logic [TickW-1:0] dead_ticks_reg;

    dir_t             dir_reg, dir_next;
    phase_t           phase_reg, phase_next;
    logic [TickW-1:0] timer_reg, timer_next;
    logic [DutyW-1:0] duty_reg, duty_next;
    logic             pend_reg, pend_next;
    logic             armed_reg, armed_next;
    logic [DebW-1:0]  cnt_reg, cnt_next;
    logic [DutyW-1:0] lcmp_reg, lcmp_next;
    logic [DutyW-1:0] rcmp_reg, rcmp_next;
    logic             llow_reg, llow_next;
    logic             rlow_reg, rlow_next;
    logic             run_reg, run_next;
    logic             led_reg, led_next;

    result_t          out_reg, skid_reg, res_next;
    logic             out_valid_reg, skid_valid_reg;

    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic             push, pop;
    logic [TickW-1:0] dead_len;
    logic [TickW-1:0] timer_dec;
    logic [DutyW-1:0] dm1;
    dir_t             want;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_DEBOUNCE: prdata = {{(DataW-TickW){1'b0}}, debounce_ticks_reg};
            REG_FAST:     prdata = {{(DataW-DutyW){1'b0}}, fast_duty_reg};
            REG_SLOW:     prdata = {{(DataW-DutyW){1'b0}}, slow_duty_reg};
            REG_START:    prdata = {{(DataW-DutyW){1'b0}}, start_duty_reg};
            REG_DEAD:     prdata = {{(DataW-TickW){1'b0}}, dead_ticks_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DebounceTicksRst;
            fast_duty_reg      <= FastDutyRst;
            slow_duty_reg      <= SlowDutyRst;
            start_duty_reg     <= StartDutyRst;
            dead_ticks_reg     <= DeadTicksRst;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DEBOUNCE: debounce_ticks_reg <= pwdata[TickW-1:0];
                REG_FAST:     fast_duty_reg      <= pwdata[DutyW-1:0];
                REG_SLOW:     slow_duty_reg      <= pwdata[DutyW-1:0];
                REG_START:    start_duty_reg     <= pwdata[DutyW-1:0];
                REG_DEAD:     dead_ticks_reg     <= pwdata[TickW-1:0];
                default:      ;
            endcase
        end
    end

    assign item_stall = skid_valid_reg;
    assign push       = item_valid & ~item_stall;
    assign pop        = out_valid_reg & ~result_stall;

    assign dead_len  = (dead_ticks_reg == '0) ? TickW'(1) : dead_ticks_reg;
    assign timer_dec = timer_reg - TickW'(1);
    assign want      = forward_switch ? DIR_FWD : DIR_BACK;
    assign dm1       = (duty_next == '0) ? '0 : duty_next - DutyW'(1);

    always_comb
    begin
        cnt_next   = cnt_reg;
        armed_next = armed_reg;
        duty_next  = duty_reg;
        pend_next  = pend_reg;
        led_next   = led_reg;
        dir_next   = dir_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        lcmp_next  = lcmp_reg;
        rcmp_next  = rcmp_reg;
        llow_next  = llow_reg;
        rlow_next  = rlow_reg;
        run_next   = run_reg;

        if (armed_reg && cnt_reg != '1)
            cnt_next = cnt_reg + DebW'(1);

        if (fast_edge)
        begin
            armed_next = 1'b1;
            if (cnt_next > {{(DebW-TickW){1'b0}}, debounce_ticks_reg})
            begin
                duty_next  = fast_duty_reg;
                cnt_next   = '0;
                armed_next = 1'b0;
                pend_next  = 1'b1;
                led_next   = 1'b1;
            end
        end
        if (slow_edge)
        begin
            armed_next = 1'b1;
            if (cnt_next > {{(DebW-TickW){1'b0}}, debounce_ticks_reg})
            begin
                duty_next  = slow_duty_reg;
                cnt_next   = '0;
                armed_next = 1'b0;
                pend_next  = 1'b1;
            end
        end

        if (phase_reg != PH_NONE)
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                if (phase_reg == PH_STOP)
                begin
                    run_next = 1'b0;
                    if (dir_reg == DIR_FWD)
                        llow_next = 1'b0;
                    else
                        rlow_next = 1'b0;
                    phase_next = PH_RAISE;
                    timer_next = dead_len;
                end
                else
                begin
                    if (dir_reg == DIR_FWD)
                    begin
                        rlow_next = 1'b1;
                        lcmp_next = dm1;
                    end
                    else
                    begin
                        llow_next = 1'b1;
                        rcmp_next = dm1;
                        led_next  = 1'b0;
                    end
                    run_next   = 1'b1;
                    phase_next = PH_NONE;
                end
            end
        end
        else
        begin
            if (pend_next)
            begin
                if (want == DIR_FWD)
                    lcmp_next = dm1;
                else
                    rcmp_next = dm1;
                pend_next = 1'b0;
            end
            if (dir_reg != want)
            begin
                lcmp_next  = '0;
                rcmp_next  = '0;
                dir_next   = want;
                phase_next = PH_STOP;
                timer_next = dead_len;
            end
        end

        res_next.left_compare  = lcmp_next;
        res_next.right_compare = rcmp_next;
        res_next.left_low_on   = llow_next;
        res_next.right_low_on  = rlow_next;
        res_next.pwm_running   = run_next;
        res_next.led_on        = led_next;
        res_next.direction     = dir_next;
        res_next.switching     = (phase_next != PH_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= DIR_IDLE;
            phase_reg <= PH_NONE;
            timer_reg <= '0;
            duty_reg  <= StartDutyRst;
            pend_reg  <= 1'b0;
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
            lcmp_reg  <= '0;
            rcmp_reg  <= '0;
            llow_reg  <= 1'b0;
            rlow_reg  <= 1'b0;
            run_reg   <= 1'b0;
            led_reg   <= 1'b0;
        end
        else if (push)
        begin
            dir_reg   <= dir_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            duty_reg  <= duty_next;
            pend_reg  <= pend_next;
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
            lcmp_reg  <= lcmp_next;
            rcmp_reg  <= rcmp_next;
            llow_reg  <= llow_next;
            rlow_reg  <= rlow_next;
            run_reg   <= run_next;
            led_reg   <= led_next;
        end
    end

    // two-entry output stage; skid fills only while the result register waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= push;
        end
        else if (push)
        begin
            if (!out_valid_reg)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res_next;
        end
        else if (push)
        begin
            if (!out_valid_reg)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign left_compare  = out_reg.left_compare;
    assign right_compare = out_reg.right_compare;
    assign left_low_on   = out_reg.left_low_on;
    assign right_low_on  = out_reg.right_low_on;
    assign pwm_running   = out_reg.pwm_running;
    assign led_on        = out_reg.led_on;
    assign direction     = out_reg.direction;
    assign switching     = out_reg.switching;

endmodule
